// File: src/bpa_pkg.sv
// Shared types, codes and command/status bundles of the buddy page allocator.
package bpa_pkg;

    localparam int FRAME_W   = 20;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] PAGES_RESET = 11'd1024;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OOM       = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGES = 2'd1;

    typedef struct packed {
        logic               action;
        logic [COUNT_W-1:0] page_count;
        logic [FRAME_W-1:0] page_frame;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] block_frame;
        logic [COUNT_W-1:0] free_pages;
    } t_out_word;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SET_ST,
        OP_ASRCH,
        OP_SPLIT_SEL,
        OP_SPLIT_LO,
        OP_SPLIT_HI,
        OP_SPLIT_DEC,
        OP_TAKE,
        OP_AFIN,
        OP_F_ADD,
        OP_J_BUD,
        OP_J_P,
        OP_J_UP,
        OP_UL_RD,
        OP_UL_NB,
        OP_UL_CL,
        OP_PU_W1,
        OP_PU_W2,
        OP_FL_RD,
        OP_FL_WR,
        OP_RB_INIT,
        OP_CLR,
        OP_RB_CARVE,
        OP_RB_NEXT,
        OP_RB_BIG
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] st;
        logic       out_load;
        logic       cfg_we;
    } t_dp_cmd;

    typedef struct packed {
        logic too_large;
        logic is_free;
        logic none_found;
        logic o_gt_ord;
        logic free_bad;
        logic onl_nz;
        logic join_ok;
        logic bud_match;
        logic clr_last;
        logic ro_last;
        logic rb_bit;
        logic rb_fit;
    } t_dp_stat;

endpackage

// File: src/buddy_page_allocator_core.sv
// Top level of the buddy page allocator: controller and datapath.
//
//  Channel  Handshake                 Word
//  -------  ------------------------  ------------------------------------
//  in       i_in_valid / o_in_stall    i_in_word  (action, page_count, page_frame)
//  out      o_out_valid / i_out_stall  o_out_word (status, block_frame, free_pages)
//  cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An allocate takes longer for each order that has to be split, and a free
// takes longer for each buddy join. The work is set by the single-port link,
// tag and parity memories: every list push, unlink and parity flip is a read
// followed by one or more writes.
// Reset and every write of a register run a rebuild: a clearing pass over
// every entry of the memories, then a list push for each initial block.
// The input is stalled during the rebuild and while an item is at work. A
// finished result waits in the output register, and the next word is taken
// while it waits; only the second result then stalls until the first is taken.
module buddy_page_allocator_core #(
    parameter int MAX_PAGES  = 1024,
    parameter int NUM_ORDERS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bpa_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bpa_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpa_pkg::FRAME_W-1:0]   i_cfg_data
);
    import bpa_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Register writes are always taken; one restarts the rebuild.
    assign o_cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bpa_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .NUM_ORDERS (NUM_ORDERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_word   (i_in_word),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_word  (o_out_word)
    );

endmodule

// File: src/bpa_datapath.sv
// Datapath of the buddy page allocator: link, list and parity memories plus working registers.
module bpa_datapath #(
    parameter int MAX_PAGES  = 1024,
    parameter int NUM_ORDERS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bpa_pkg::t_dp_cmd                i_cmd,
    output bpa_pkg::t_dp_stat               o_stat,
    input  bpa_pkg::t_in_word               i_in_word,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpa_pkg::FRAME_W-1:0]     i_cfg_data,
    output bpa_pkg::t_out_word              o_out_word
);
    import bpa_pkg::*;

    localparam int AW  = $clog2(MAX_PAGES);
    localparam int PW  = $clog2(MAX_PAGES + 1);
    localparam int OW  = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam int LW  = $clog2(NUM_ORDERS + 1);
    localparam int BIG = 1 << (NUM_ORDERS - 1);
    localparam logic [PW-1:0] NIL = PW'(MAX_PAGES);

    // Memories: per-page links, per-page list tag, per-pair parity word.
    logic [PW-1:0]         m_nxt [MAX_PAGES];
    logic [PW-1:0]         m_prv [MAX_PAGES];
    logic [LW-1:0]         m_onl [MAX_PAGES];
    logic [NUM_ORDERS-1:0] m_par [MAX_PAGES];

    logic [FRAME_W-1:0]    r_base;
    logic [COUNT_W-1:0]    r_pages;
    logic [PW-1:0]         r_head [NUM_ORDERS];
    logic [COUNT_W-1:0]    r_free;
    logic                  r_act;
    logic                  r_big;
    logic [OW-1:0]         r_ord;
    logic [OW-1:0]         r_o;
    logic [FRAME_W-1:0]    r_off;
    logic [AW-1:0]         r_p;
    logic [AW-1:0]         r_sp;
    logic [OW-1:0]         r_so;
    logic [PW-1:0]         r_h;
    logic [1:0]            r_status;
    logic [FRAME_W-1:0]    r_block;
    logic [PW-1:0]         r_rd_nxt;
    logic [PW-1:0]         r_rd_prv;
    logic [LW-1:0]         r_rd_onl;
    logic [NUM_ORDERS-1:0] r_rd_par;
    logic [AW-1:0]         r_pidx;
    logic                  r_pbit;
    logic [AW-1:0]         r_clr;
    logic [COUNT_W-1:0]    r_end;
    logic [COUNT_W-1:0]    r_cur;
    logic [OW-1:0]         r_ro;
    t_out_word             r_out;

    logic [COUNT_W-1:0]    w_n;
    logic [OW-1:0]         w_ord;
    logic [FRAME_W-1:0]    w_off;
    logic                  w_found;
    logic [OW-1:0]         w_fo;
    logic [AW-1:0]         w_bud;
    logic [AW-1:0]         w_low;
    logic [AW-1:0]         w_pidx;
    logic [NUM_ORDERS-1:0] w_pmask;
    logic [NUM_ORDERS-1:0] w_par_new;

    logic                  we_nxt, we_prv, we_onl, we_par;
    logic [AW-1:0]         wa_nxt, wa_prv, wa_onl, wa_par;
    logic [PW-1:0]         wd_nxt, wd_prv;
    logic [LW-1:0]         wd_onl;
    logic [NUM_ORDERS-1:0] wd_par;

    assign w_n   = (int'(r_pages) > MAX_PAGES) ? COUNT_W'(MAX_PAGES) : r_pages;
    assign w_off = i_in_word.page_frame - r_base;
    assign w_bud = r_p ^ AW'(1 << r_o);
    assign w_low = (r_p < w_bud) ? r_p : w_bud;
    assign w_pidx = AW'(r_sp >> (int'(r_so) + 1));
    assign w_pmask = NUM_ORDERS'(1) << (int'(r_so) + 1);
    assign w_par_new = r_rd_par ^ w_pmask;

    // Order of the request: smallest order whose block covers page_count.
    always_comb begin
        w_ord = '0;
        for (int o = NUM_ORDERS - 1; o >= 0; o--) begin
            if ((1 << o) >= int'(i_in_word.page_count)) begin
                w_ord = OW'(o);
            end
        end
    end

    // Smallest non-empty list at or above the requested order.
    always_comb begin
        w_found = 1'b0;
        w_fo    = '0;
        for (int o = NUM_ORDERS - 1; o >= 0; o--) begin
            if (o >= int'(r_ord) && r_head[o] != NIL) begin
                w_found = 1'b1;
                w_fo    = OW'(o);
            end
        end
    end

    always_comb begin
        o_stat.too_large  = r_big;
        o_stat.is_free    = r_act;
        o_stat.none_found = !w_found;
        o_stat.o_gt_ord   = r_o > r_ord;
        o_stat.free_bad   = (int'(r_off) >= int'(w_n))
                         || ((int'(r_off) & ((1 << r_ord) - 1)) != 0)
                         || (int'(r_off) + (1 << r_ord) > int'(w_n));
        o_stat.onl_nz     = r_rd_onl != '0;
        o_stat.join_ok    = (int'(r_o) + 1 < NUM_ORDERS) && !r_pbit
                         && (int'(w_bud) + (1 << r_o) <= int'(w_n));
        o_stat.bud_match  = r_rd_onl == LW'(int'(r_o) + 1);
        o_stat.clr_last   = int'(r_clr) == MAX_PAGES - 1;
        o_stat.ro_last    = int'(r_ro) == NUM_ORDERS - 1;
        o_stat.rb_bit     = ((int'(w_n) >> r_ro) & 1) != 0;
        o_stat.rb_fit     = int'(r_cur) + BIG <= int'(r_end);
    end

    // Memory write selection.
    always_comb begin
        we_nxt = 1'b0; wa_nxt = r_sp; wd_nxt = NIL;
        we_prv = 1'b0; wa_prv = r_sp; wd_prv = NIL;
        we_onl = 1'b0; wa_onl = r_sp; wd_onl = '0;
        we_par = 1'b0; wa_par = r_pidx; wd_par = w_par_new;
        case (i_cmd.op)
            OP_UL_NB: begin
                if (r_rd_onl != '0) begin
                    if (r_rd_prv != NIL) begin
                        we_nxt = 1'b1;
                        wa_nxt = r_rd_prv[AW-1:0];
                        wd_nxt = r_rd_nxt;
                    end
                    if (r_rd_nxt != NIL) begin
                        we_prv = 1'b1;
                        wa_prv = r_rd_nxt[AW-1:0];
                        wd_prv = r_rd_prv;
                    end
                end
            end
            OP_UL_CL: begin
                we_nxt = 1'b1;
                we_prv = 1'b1;
                we_onl = 1'b1;
            end
            OP_PU_W1: begin
                we_nxt = 1'b1;
                wd_nxt = r_head[r_so];
                we_prv = 1'b1;
                we_onl = 1'b1;
                wd_onl = LW'(int'(r_so) + 1);
            end
            OP_PU_W2: begin
                if (r_h != NIL) begin
                    we_prv = 1'b1;
                    wa_prv = r_h[AW-1:0];
                    wd_prv = PW'(r_sp);
                end
            end
            OP_FL_WR: begin
                we_par = (int'(r_so) + 1 < NUM_ORDERS);
            end
            OP_CLR: begin
                we_nxt = 1'b1; wa_nxt = r_clr;
                we_prv = 1'b1; wa_prv = r_clr;
                we_onl = 1'b1; wa_onl = r_clr;
                we_par = 1'b1; wa_par = r_clr; wd_par = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_nxt) m_nxt[wa_nxt] <= wd_nxt;
        if (we_prv) m_prv[wa_prv] <= wd_prv;
        if (we_onl) m_onl[wa_onl] <= wd_onl;
        if (we_par) m_par[wa_par] <= wd_par;
        if (i_cmd.op == OP_UL_RD) begin
            r_rd_nxt <= m_nxt[r_sp];
            r_rd_prv <= m_prv[r_sp];
            r_rd_onl <= m_onl[r_sp];
        end
        if (i_cmd.op == OP_FL_RD) begin
            r_rd_par <= m_par[w_pidx];
            r_pidx   <= w_pidx;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_pages <= PAGES_RESET;
        end else if (i_cmd.cfg_we) begin
            case (i_cfg_index)
                REG_BASE:  r_base  <= i_cfg_data;
                REG_PAGES: r_pages <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Working registers, list heads and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status      <= r_status;
            r_out.block_frame <= r_block;
            r_out.free_pages  <= r_free;
        end
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_act    <= i_in_word.action;
                r_big    <= int'(i_in_word.page_count) > BIG;
                r_ord    <= w_ord;
                r_o      <= w_ord;
                r_so     <= w_ord;
                r_off    <= w_off;
                r_sp     <= w_off[AW-1:0];
                r_p      <= w_off[AW-1:0];
                r_status <= ST_OK;
                r_block  <= '0;
            end
            OP_SET_ST:    r_status <= i_cmd.st;
            OP_ASRCH:     r_o <= w_fo;
            OP_SPLIT_SEL: begin
                r_p  <= r_head[r_o][AW-1:0];
                r_sp <= r_head[r_o][AW-1:0];
                r_so <= r_o;
            end
            OP_SPLIT_LO: begin
                r_so <= r_o - OW'(1);
                r_sp <= r_p;
            end
            OP_SPLIT_HI:  r_sp <= r_p + AW'(1 << (int'(r_o) - 1));
            OP_SPLIT_DEC: r_o <= r_o - OW'(1);
            OP_TAKE: begin
                r_p  <= r_head[r_ord][AW-1:0];
                r_sp <= r_head[r_ord][AW-1:0];
                r_so <= r_ord;
            end
            OP_AFIN: begin
                r_free  <= (int'(r_free) >= (1 << r_ord))
                         ? COUNT_W'(int'(r_free) - (1 << r_ord)) : '0;
                r_block <= r_base + FRAME_W'(r_p);
            end
            OP_F_ADD: begin
                r_free <= (int'(r_free) + (1 << r_ord) > int'(w_n))
                        ? w_n : COUNT_W'(int'(r_free) + (1 << r_ord));
            end
            OP_J_BUD: r_sp <= w_bud;
            OP_J_P:   r_sp <= r_p;
            OP_J_UP: begin
                r_p  <= w_low;
                r_sp <= w_low;
                r_o  <= r_o + OW'(1);
                r_so <= r_o + OW'(1);
            end
            OP_UL_NB: begin
                if (r_rd_onl != '0 && r_rd_prv == NIL) begin
                    r_head[OW'(int'(r_rd_onl) - 1)] <= r_rd_nxt;
                end
            end
            OP_PU_W1: begin
                r_h          <= r_head[r_so];
                r_head[r_so] <= PW'(r_sp);
            end
            OP_FL_WR:   r_pbit <= |(w_par_new & w_pmask);
            OP_RB_INIT: begin
                r_clr  <= '0;
                r_end  <= w_n;
                r_cur  <= '0;
                r_ro   <= '0;
                r_free <= w_n;
                for (int o = 0; o < NUM_ORDERS; o++) begin
                    r_head[o] <= NIL;
                end
            end
            OP_CLR:      r_clr <= r_clr + AW'(1);
            OP_RB_CARVE: begin
                r_end <= COUNT_W'(int'(r_end) - (1 << r_ro));
                r_sp  <= AW'(int'(r_end) - (1 << r_ro));
                r_so  <= r_ro;
            end
            OP_RB_NEXT:  r_ro <= r_ro + OW'(1);
            OP_RB_BIG: begin
                r_sp  <= AW'(r_cur);
                r_so  <= OW'(NUM_ORDERS - 1);
                r_cur <= COUNT_W'(int'(r_cur) + BIG);
            end
            default: begin
            end
        endcase
    end

    assign o_out_word = r_out;

endmodule

// File: src/bpa_ctrl.sv
// Controller state machine of the buddy page allocator.
module bpa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_cfg_valid,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  bpa_pkg::t_dp_stat             i_stat,
    output bpa_pkg::t_dp_cmd              o_cmd
);
    import bpa_pkg::*;

    typedef enum logic [5:0] {
        S_RB_INIT, S_CLR, S_RB_ORD, S_RB_NEXT, S_RB_BIG,
        S_IDLE, S_DECODE, S_DONE,
        S_ASRCH, S_ACHK, S_SPL_SEL, S_SPL_FL, S_SPL_LO, S_SPL_HI, S_SPL_DEC,
        S_TAKE, S_TAKE_FL, S_AFIN,
        S_FCHK, S_FADD, S_JTEST, S_JRD, S_JCHK, S_JP, S_JUP, S_JFL,
        S_UL_RD, S_UL_NB, S_UL_CL,
        S_PU_RD, S_PU_NB, S_PU_W1, S_PU_W2,
        S_FL_RD, S_FL_WR
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_in_stall;
    logic   r_out_valid;

    always_comb begin
        n_state         = r_state;
        n_ret           = r_ret;
        o_cmd.op        = OP_NOP;
        o_cmd.st        = ST_OK;
        o_cmd.out_load  = 1'b0;
        o_cmd.cfg_we    = 1'b0;
        case (r_state)
            S_RB_INIT: begin
                o_cmd.op = OP_RB_INIT;
                n_state  = S_CLR;
            end
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_last) n_state = S_RB_ORD;
            end
            S_RB_ORD: begin
                if (i_stat.ro_last) begin
                    n_state = S_RB_BIG;
                end else if (i_stat.rb_bit) begin
                    o_cmd.op = OP_RB_CARVE;
                    n_state  = S_PU_RD;
                    n_ret    = S_RB_NEXT;
                end else begin
                    o_cmd.op = OP_RB_NEXT;
                end
            end
            S_RB_NEXT: begin
                o_cmd.op = OP_RB_NEXT;
                n_state  = S_RB_ORD;
            end
            S_RB_BIG: begin
                if (i_stat.rb_fit) begin
                    o_cmd.op = OP_RB_BIG;
                    n_state  = S_PU_RD;
                    n_ret    = S_RB_BIG;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.too_large) begin
                    o_cmd.op = OP_SET_ST;
                    o_cmd.st = ST_TOO_LARGE;
                    n_state  = S_DONE;
                end else if (!i_stat.is_free) begin
                    n_state = S_ASRCH;
                end else if (i_stat.free_bad) begin
                    o_cmd.op = OP_SET_ST;
                    o_cmd.st = ST_BAD_ADDR;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_UL_RD;
                    n_state  = S_FCHK;
                end
            end
            S_ASRCH: begin
                if (i_stat.none_found) begin
                    o_cmd.op = OP_SET_ST;
                    o_cmd.st = ST_OOM;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_ASRCH;
                    n_state  = S_ACHK;
                end
            end
            S_ACHK: n_state = i_stat.o_gt_ord ? S_SPL_SEL : S_TAKE;
            S_SPL_SEL: begin
                o_cmd.op = OP_SPLIT_SEL;
                n_state  = S_UL_RD;
                n_ret    = S_SPL_FL;
            end
            S_SPL_FL: begin
                n_state = S_FL_RD;
                n_ret   = S_SPL_LO;
            end
            S_SPL_LO: begin
                o_cmd.op = OP_SPLIT_LO;
                n_state  = S_PU_RD;
                n_ret    = S_SPL_HI;
            end
            S_SPL_HI: begin
                o_cmd.op = OP_SPLIT_HI;
                n_state  = S_PU_RD;
                n_ret    = S_SPL_DEC;
            end
            S_SPL_DEC: begin
                o_cmd.op = OP_SPLIT_DEC;
                n_state  = S_ACHK;
            end
            S_TAKE: begin
                o_cmd.op = OP_TAKE;
                n_state  = S_UL_RD;
                n_ret    = S_TAKE_FL;
            end
            S_TAKE_FL: begin
                n_state = S_FL_RD;
                n_ret   = S_AFIN;
            end
            S_AFIN: begin
                o_cmd.op = OP_AFIN;
                n_state  = S_DONE;
            end
            S_FCHK: begin
                if (i_stat.onl_nz) begin
                    o_cmd.op = OP_SET_ST;
                    o_cmd.st = ST_BAD_ADDR;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_PU_RD;
                    n_ret   = S_FADD;
                end
            end
            S_FADD: begin
                o_cmd.op = OP_F_ADD;
                n_state  = S_FL_RD;
                n_ret    = S_JTEST;
            end
            S_JTEST: begin
                if (i_stat.join_ok) begin
                    o_cmd.op = OP_J_BUD;
                    n_state  = S_JRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_JRD: begin
                o_cmd.op = OP_UL_RD;
                n_state  = S_JCHK;
            end
            S_JCHK: begin
                if (i_stat.bud_match) begin
                    n_state = S_UL_NB;
                    n_ret   = S_JP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_JP: begin
                o_cmd.op = OP_J_P;
                n_state  = S_UL_RD;
                n_ret    = S_JUP;
            end
            S_JUP: begin
                o_cmd.op = OP_J_UP;
                n_state  = S_PU_RD;
                n_ret    = S_JFL;
            end
            S_JFL: begin
                n_state = S_FL_RD;
                n_ret   = S_JTEST;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_UL_RD: begin
                o_cmd.op = OP_UL_RD;
                n_state  = S_UL_NB;
            end
            S_UL_NB: begin
                o_cmd.op = OP_UL_NB;
                n_state  = S_UL_CL;
            end
            S_UL_CL: begin
                o_cmd.op = OP_UL_CL;
                n_state  = r_ret;
            end
            S_PU_RD: begin
                o_cmd.op = OP_UL_RD;
                n_state  = S_PU_NB;
            end
            S_PU_NB: begin
                o_cmd.op = OP_UL_NB;
                n_state  = S_PU_W1;
            end
            S_PU_W1: begin
                o_cmd.op = OP_PU_W1;
                n_state  = S_PU_W2;
            end
            S_PU_W2: begin
                o_cmd.op = OP_PU_W2;
                n_state  = r_ret;
            end
            S_FL_RD: begin
                o_cmd.op = OP_FL_RD;
                n_state  = S_FL_WR;
            end
            S_FL_WR: begin
                o_cmd.op = OP_FL_WR;
                n_state  = r_ret;
            end
            default: n_state = S_RB_INIT;
        endcase
        // A register write restarts the rebuild of all lists.
        if (i_cfg_valid && (i_cfg_index == REG_BASE || i_cfg_index == REG_PAGES)) begin
            o_cmd.cfg_we = 1'b1;
            n_state      = S_RB_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RB_INIT;
            r_ret       <= S_IDLE;
            r_in_stall  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_in_stall <= (n_state != S_IDLE);
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

// File: src/bpa_checker.sv
// Port-level assertions of the buddy page allocator and their binding.
module bpa_port_checks (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input bpa_pkg::t_in_word             i_in_word,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input bpa_pkg::t_out_word            o_out_word,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [bpa_pkg::FRAME_W-1:0]   i_cfg_data
);
    import bpa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("result word changed while stalled");

    a_fail_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |-> o_out_word.block_frame == '0)
        else $error("failed request carries a block frame");

    a_reset_rebuild: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_BASE || i_cfg_index == REG_PAGES)
        |=> o_in_stall)
        else $error("input not stalled during rebuild");

endmodule

bind buddy_page_allocator_core bpa_port_checks u_bpa_checker (.*);

// File: tb/sv/bpa_checker.sv
`timescale 1ns / 1ps
// Allocator checker: predicts every result word from the accepted words and compares it.
module bpa_checker
    import bpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_word,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [FRAME_W-1:0]    i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int NPG     = 1024;
    localparam int NORD    = 8;
    localparam int NIL     = NPG;
    localparam logic ACT_FREE = 1'b1;

    int                 nxt_pg [NPG];
    int                 prv_pg [NPG];
    int                 head_pg [NORD];
    bit                 pair_bit [NORD][NPG];
    int                 listed [NPG];
    int                 free_cnt;
    logic [FRAME_W-1:0] base_frame;
    logic [COUNT_W-1:0] region_sz;

    t_out_word expected_words[$];

    function automatic int pages_used();
        return (region_sz > NPG) ? NPG : int'(region_sz);
    endfunction

    function automatic void unlink_pg(int p);
        int o, nx, pv;
        if (p >= NIL || listed[p] == 0) return;
        o  = listed[p] - 1;
        nx = nxt_pg[p];
        pv = prv_pg[p];
        if (pv < NIL) nxt_pg[pv] = nx;
        else head_pg[o] = nx;
        if (nx < NIL) prv_pg[nx] = pv;
        nxt_pg[p] = NIL;
        prv_pg[p] = NIL;
        listed[p] = 0;
    endfunction

    function automatic void push_pg(int o, int p);
        int h;
        if (p >= NIL || o >= NORD) return;
        unlink_pg(p);
        h = head_pg[o];
        nxt_pg[p] = h;
        prv_pg[p] = NIL;
        if (h < NIL) prv_pg[h] = p;
        head_pg[o] = p;
        listed[p] = o + 1;
    endfunction

    function automatic int pop_pg(int o);
        int p;
        p = head_pg[o];
        unlink_pg(p);
        return p;
    endfunction

    function automatic void flip_pair(int o, int p);
        if (o + 1 < NORD) pair_bit[o+1][(p >> (o + 1)) & (NPG - 1)] ^= 1'b1;
    endfunction

    // Lists are rebuilt from scratch: small blocks from the top, the rest in
    // largest-order blocks pushed upward so that the highest one heads its list.
    function automatic void rebuild_lists();
        int n, top_end, cur;
        n = pages_used();
        top_end = n;
        for (int i = 0; i < NPG; i++) begin
            nxt_pg[i] = NIL;
            prv_pg[i] = NIL;
            listed[i] = 0;
            for (int o = 0; o < NORD; o++) pair_bit[o][i] = 0;
        end
        for (int o = 0; o < NORD; o++) head_pg[o] = NIL;
        for (int o = 0; o + 1 < NORD; o++) begin
            if (n & (1 << o)) begin
                top_end -= (1 << o);
                push_pg(o, top_end);
            end
        end
        for (cur = 0; cur + (1 << (NORD - 1)) <= top_end; cur += (1 << (NORD - 1)))
            push_pg(NORD - 1, cur);
        free_cnt = n;
    endfunction

    function automatic t_out_word serve_request(t_in_word w);
        t_out_word r;
        int ord, o, p, n, off, sz, bud, lowp;
        n = pages_used();
        r = '0;
        r.status = ST_OK;
        ord = 0;
        while (ord < NORD && (1 << ord) < int'(w.page_count)) ord++;
        if (ord >= NORD) begin
            r.status = ST_TOO_LARGE;
        end else if (w.action != ACT_FREE) begin
            o = ord;
            while (o < NORD && head_pg[o] >= NIL) o++;
            if (o >= NORD) begin
                r.status = ST_OOM;
            end else begin
                // Split down to the asked order; the upper half ends up on top.
                while (o > ord) begin
                    p = pop_pg(o);
                    flip_pair(o, p);
                    push_pg(o - 1, p);
                    push_pg(o - 1, p + (1 << (o - 1)));
                    o--;
                end
                p = pop_pg(ord);
                flip_pair(ord, p);
                free_cnt = (free_cnt >= (1 << ord)) ? free_cnt - (1 << ord) : 0;
                r.block_frame = base_frame + FRAME_W'(p);
            end
        end else begin
            off = int'(FRAME_W'(w.page_frame - base_frame));
            sz  = 1 << ord;
            if (off >= n || (off & (sz - 1)) != 0 || off + sz > n || listed[off] != 0) begin
                r.status = ST_BAD_ADDR;
            end else begin
                o = ord;
                p = off;
                push_pg(o, p);
                free_cnt += sz;
                if (free_cnt > n) free_cnt = n;
                flip_pair(o, p);
                // Join with the buddy while the pair bit says both halves are free.
                while (o + 1 < NORD && pair_bit[o+1][(p >> (o + 1)) & (NPG - 1)] == 0) begin
                    bud = p ^ (1 << o);
                    if (bud + (1 << o) > n || listed[bud] != o + 1) break;
                    unlink_pg(p);
                    unlink_pg(bud);
                    lowp = (p < bud) ? p : bud;
                    o++;
                    push_pg(o, lowp);
                    flip_pair(o, lowp);
                    p = lowp;
                end
            end
        end
        r.free_pages = COUNT_W'(free_cnt);
        return r;
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_out_word want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            base_frame  = '0;
            region_sz   = PAGES_RESET;
            rebuild_lists();
            o_errors   <= 0;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_BASE) begin
                    base_frame = i_cfg_data;
                    rebuild_lists();
                end else if (i_cfg_index == REG_PAGES) begin
                    region_sz = i_cfg_data[COUNT_W-1:0];
                    rebuild_lists();
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(serve_request(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: %h", i_out_word);
                    errs++;
                end else begin
                    want = expected_words.pop_front();
                    if (want.status !== i_out_word.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               i_out_word.status);
                        errs++;
                    end
                    if (want.block_frame !== i_out_word.block_frame) begin
                        $error("block_frame: expected %h, got %h", want.block_frame,
                               i_out_word.block_frame);
                        errs++;
                    end
                    if (want.free_pages !== i_out_word.free_pages) begin
                        $error("free_pages: expected %0d, got %0d", want.free_pages,
                               i_out_word.free_pages);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_errors <= o_errors + errs;
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus for the allocator and the final verdict.
module testbench;
    import bpa_pkg::*;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   NPHASE = 7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FRAME_W-1:0]   i_cfg_data = '0;

    int errors, pending;
    int quiet_cycles = 0;
    bit idle_en = 1'b1;

    // The testbench's own view of the region, used to aim frees at real blocks.
    logic [FRAME_W-1:0] cur_base = '0;
    int                 cur_pages = 1024;

    // Region settings per phase; the first phase runs on the reset values.
    logic [FRAME_W-1:0] phase_base [NPHASE] = '{20'h00000, 20'h12345, 20'h00000,
                                                  20'hFFFFF, 20'hFFF80, 20'h00400,
                                                  20'h00000};
    int phase_pages [NPHASE] = '{1024, 1000, 0, 1, 1024, 777, 1024};
    int phase_items [NPHASE] = '{280, 280, 30, 60, 360, 360, 360};

    always #6 i_clk = ~i_clk;

    buddy_page_allocator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    bpa_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // The watchdog counts cycles in which no channel moves a word. The longest
    // honest quiet stretch is a rebuild.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The result side stalls in random bursts while idling is enabled.
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Presents one word and holds it until the block takes it. Valid stays
    // high into the next word unless a gap burst is drawn.
    task automatic send_word(input t_in_word w);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_req(input logic act, input int cnt, input logic [FRAME_W-1:0] frame);
        t_in_word w;
        w.action     = act;
        w.page_count = COUNT_W'(cnt);
        w.page_frame = frame;
        send_word(w);
    endtask

    // Lets every outstanding result drain before the sender moves on. It waits
    // on the clock first so that a word taken at the current edge is counted.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed allocate and free words with small orders; a few
    // words carry fully random fields to exercise every bit and the errors.
    function automatic t_in_word random_word();
        t_in_word w;
        int ord, sz, span, off, pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) ord = $urandom_range(0, 2);
        else if (pick < 85) ord = $urandom_range(3, 5);
        else ord = $urandom_range(6, 7);
        sz = 1 << ord;
        w.page_count = (ord == 0) ? COUNT_W'(1) : COUNT_W'($urandom_range(sz / 2 + 1, sz));
        w.action = ($urandom_range(0, 99) < 52) ? ACT_ALLOC : ACT_FREE;
        span = (cur_pages > 0) ? cur_pages : 1;
        off = $urandom_range(0, span - 1) & ~(sz - 1);
        w.page_frame = cur_base + FRAME_W'(off);
        if ($urandom_range(0, 99) < 6) begin
            w.action     = 1'($urandom);
            w.page_count = COUNT_W'($urandom);
            w.page_frame = FRAME_W'($urandom);
        end
        return w;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words on the reset region: extremes of sizes and addresses,
        // splits down from the largest order, joins back up, and bad frees.
        send_req(ACT_ALLOC, 1, '0);
        send_req(ACT_ALLOC, 0, '0);
        send_req(ACT_ALLOC, 128, '0);
        send_req(ACT_ALLOC, 129, '0);
        send_req(ACT_FREE, 1024, 20'h00000);
        send_req(ACT_ALLOC, 2047, '0);
        send_req(ACT_ALLOC, 3, '0);
        send_req(ACT_FREE, 1, 20'h003FF);
        send_req(ACT_FREE, 1, 20'h003FE);
        send_req(ACT_FREE, 2, 20'h00001);
        send_req(ACT_FREE, 1, 20'h00400);
        send_req(ACT_FREE, 1, 20'hFFFFF);
        send_req(ACT_FREE, 128, 20'h00380);
        send_req(ACT_FREE, 4, 20'h003F8);
        send_req(ACT_FREE, 4, 20'h003FC);
        send_req(ACT_ALLOC, 64, '0);
        send_req(ACT_FREE, 64, 20'h00340);
        send_req(ACT_FREE, 128, 20'h00300);
        send_req(ACT_FREE, 128, 20'h00000);
        send_req(ACT_ALLOC, 2, '0);
        send_req(ACT_FREE, 2, 20'h00000);
        // The sender waits here for every result before going on.
        drain();

        for (int ph = 0; ph < NPHASE; ph++) begin
            if (ph > 0) begin
                drain();
                idle_en = (ph != NPHASE - 1);
                cur_base  = phase_base[ph];
                cur_pages = phase_pages[ph];
                write_reg(REG_BASE, phase_base[ph]);
                write_reg(REG_PAGES, FRAME_W'(phase_pages[ph]));
            end
            for (int k = 0; k < phase_items[ph]; k++) begin
                // An idle-free stretch in the middle of each phase.
                if (ph != NPHASE - 1)
                    idle_en = !(k > phase_items[ph] / 2 && k < phase_items[ph] * 3 / 4);
                send_word(random_word());
            end
            if (ph != NPHASE - 1) idle_en = 1'b1;
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
